>>> src/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg: shared definitions of the mandelbrot pixel generator
// Field widths, reset values, register indexes, sequencer states and the
// constant blue color table.
// ----------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

    // default values of the top level parameters
    localparam int MAX_ITER_DEF  = 255;
    localparam int FRAC_BITS_DEF = 28;
    localparam int DIM_BITS_DEF  = 12;

    // register and port field widths
    localparam int CX_W       = 31;
    localparam int PITCH_W    = 28;
    localparam int FRAME_W    = 13;
    localparam int ITER_W     = 8;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic signed [CX_W-1:0] RST_CENTER_X = -31'sd134217728;
    localparam logic signed [CX_W-1:0] RST_CENTER_Y = 31'sd0;
    localparam logic [PITCH_W-1:0]     RST_PITCH_X  = 28'd734003;
    localparam logic [PITCH_W-1:0]     RST_PITCH_Y  = 28'd1305670;
    localparam logic [FRAME_W-1:0]     RST_FRAME_W  = 13'd1280;
    localparam logic [FRAME_W-1:0]     RST_FRAME_H  = 13'd720;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_PITCH_X      = 3'd2,
        CFG_PITCH_Y      = 3'd3,
        CFG_FRAME_WIDTH  = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CX_W-1:0] center_x;
        logic signed [CX_W-1:0] center_y;
        logic [PITCH_W-1:0]     pitch_x;
        logic [PITCH_W-1:0]     pitch_y;
        logic [FRAME_W-1:0]     frame_width;
        logic [FRAME_W-1:0]     frame_height;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_ADD,
        ST_IT_MUL,
        ST_IT_ADD,
        ST_DONE
    } t_state;

    typedef logic [255:0][7:0] t_blue_lut;

    // taylor series divisors (2k)*(2k+1) for k = 1..12
    localparam logic [11:0][63:0] SIN_DIV = {
        64'd600, 64'd506, 64'd420, 64'd342, 64'd272, 64'd210,
        64'd156, 64'd110, 64'd72,  64'd42,  64'd20,  64'd6
    };

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
    localparam logic [63:0] MSK_30  = (64'd1 << 30) - 64'd1;

    // (a*b) >> 60 for operands below 2^60
    function automatic logic [63:0] qmul60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] mid;
        ah  = a >> 30;
        al  = a & MSK_30;
        bh  = b >> 30;
        bl  = b & MSK_30;
        mid = ah * bl + al * bh + ((al * bl) >> 30);
        return ah * bh + (mid >> 30);
    endfunction

    // 127 + floor(127 * sin(n / 255)) in exact integer series arithmetic
    function automatic logic [7:0] blue_of(input logic [63:0] n);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] f;
        t    = (ONE_Q60 / 255) * n + (((ONE_Q60 % 255) * n) / 255);
        t2   = qmul60(t, t);
        term = t;
        s    = t;
        for (int k = 0; k < 12; k++) begin
            term = qmul60(term, t2) / SIN_DIV[k];
            if ((k % 2) == 0) begin
                s = s - term;
            end else begin
                s = s + term;
            end
        end
        hi = s >> 30;
        lo = s & MSK_30;
        f  = (64'd127 * hi + ((64'd127 * lo) >> 30)) >> 30;
        return 8'(64'd127 + f);
    endfunction

    function automatic t_blue_lut blue_table();
        t_blue_lut lut;
        for (int n = 0; n < 256; n++) begin
            lut[n] = blue_of(64'(n));
        end
        return lut;
    endfunction

    localparam t_blue_lut BLUE_LUT = blue_table();

endpackage

`default_nettype wire

>>> src/mbp_if.sv
// ----------------------------------------------------------------------------
// mbp_if: channel interfaces of the mandelbrot pixel generator
// Pixel request channel, result channel and register write channel, each
// with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbp_pix_if #(
    parameter int DIM_BITS = mbp_pkg::DIM_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] column;
    logic [DIM_BITS-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

interface mbp_res_if;
    logic                          valid;
    logic                          ready;
    logic [mbp_pkg::ITER_W-1:0]    iterations;
    logic [mbp_pkg::COLOR_W-1:0]   pixel_color;

    modport source (output valid, output iterations, output pixel_color, input ready);
    modport sink   (input valid, input iterations, input pixel_color, output ready);
endinterface

interface mbp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbp_pkg::CFG_IDX_W-1:0]  index;
    logic [mbp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/mbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbp_cfg_regs: view configuration registers
// Holds view center, pixel pitch and frame size, written through the
// register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_cfg_regs (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mbp_cfg_if.sink      i_cfg,
    output mbp_pkg::t_cfg o_cfg
);

    mbp_pkg::t_cfg r_cfg;
    mbp_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (mbp_pkg::t_cfg_idx'(i_cfg.index))
                mbp_pkg::CFG_CENTER_X: begin
                    n_cfg.center_x = $signed(i_cfg.data[mbp_pkg::CX_W-1:0]);
                end
                mbp_pkg::CFG_CENTER_Y: begin
                    n_cfg.center_y = $signed(i_cfg.data[mbp_pkg::CX_W-1:0]);
                end
                mbp_pkg::CFG_PITCH_X: begin
                    n_cfg.pitch_x = i_cfg.data[mbp_pkg::PITCH_W-1:0];
                end
                mbp_pkg::CFG_PITCH_Y: begin
                    n_cfg.pitch_y = i_cfg.data[mbp_pkg::PITCH_W-1:0];
                end
                mbp_pkg::CFG_FRAME_WIDTH: begin
                    n_cfg.frame_width = i_cfg.data[mbp_pkg::FRAME_W-1:0];
                end
                mbp_pkg::CFG_FRAME_HEIGHT: begin
                    n_cfg.frame_height = i_cfg.data[mbp_pkg::FRAME_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x     <= mbp_pkg::RST_CENTER_X;
            r_cfg.center_y     <= mbp_pkg::RST_CENTER_Y;
            r_cfg.pitch_x      <= mbp_pkg::RST_PITCH_X;
            r_cfg.pitch_y      <= mbp_pkg::RST_PITCH_Y;
            r_cfg.frame_width  <= mbp_pkg::RST_FRAME_W;
            r_cfg.frame_height <= mbp_pkg::RST_FRAME_H;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> src/mbp_mul_unit.sv
// ----------------------------------------------------------------------------
// mbp_mul_unit: shared multiplier set
// Three unsigned multipliers with registered products, used for the pixel
// mapping and for every escape iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_mul_unit #(
    parameter int MUL_W = 31
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [MUL_W-1:0]   i_a0,
    input  wire logic [MUL_W-1:0]   i_b0,
    input  wire logic [MUL_W-1:0]   i_a1,
    input  wire logic [MUL_W-1:0]   i_b1,
    input  wire logic [MUL_W-1:0]   i_a2,
    input  wire logic [MUL_W-1:0]   i_b2,
    output logic      [2*MUL_W-1:0] o_p0,
    output logic      [2*MUL_W-1:0] o_p1,
    output logic      [2*MUL_W-1:0] o_p2
);

    logic [2*MUL_W-1:0] r_p0;
    logic [2*MUL_W-1:0] r_p1;
    logic [2*MUL_W-1:0] r_p2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_a0 * i_b0;
            r_p1 <= i_a1 * i_b1;
            r_p2 <= i_a2 * i_b2;
        end
    end

    assign o_p0 = r_p0;
    assign o_p1 = r_p1;
    assign o_p2 = r_p2;

endmodule

`default_nettype wire

>>> src/mbp_color.sv
// ----------------------------------------------------------------------------
// mbp_color: escape count to color
// Red is the count, green the count with nibbles swapped, blue from the
// sine table; black when the point never escaped.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_color #(
    parameter int MAX_ITER = mbp_pkg::MAX_ITER_DEF
) (
    input  wire logic [mbp_pkg::ITER_W-1:0]  i_iter,
    output logic      [mbp_pkg::COLOR_W-1:0] o_color
);

    logic [7:0] green;
    logic [7:0] blue;

    assign green = {i_iter[3:0], i_iter[7:4]};
    assign blue  = mbp_pkg::BLUE_LUT[i_iter];

    always_comb begin
        if (i_iter == mbp_pkg::ITER_W'(MAX_ITER)) begin
            o_color = '0;
        end else begin
            o_color = {i_iter, green, blue};
        end
    end

endmodule

`default_nettype wire

>>> src/mbp_core.sv
// ----------------------------------------------------------------------------
// mbp_core: pixel sequencer and escape-time datapath
// Maps the pixel to a point, runs z = z^2 + c on the shared multipliers
// with one add/compare step per iteration, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_core #(
    parameter int MAX_ITER  = mbp_pkg::MAX_ITER_DEF,
    parameter int FRAC_BITS = mbp_pkg::FRAC_BITS_DEF,
    parameter int DIM_BITS  = mbp_pkg::DIM_BITS_DEF,
    parameter int MUL_W     = 31
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    mbp_pix_if.sink                           pix,
    mbp_res_if.source                         res,
    input  wire mbp_pkg::t_cfg                i_cfg,
    output logic                              o_mul_en,
    output logic      [MUL_W-1:0]             o_a0,
    output logic      [MUL_W-1:0]             o_b0,
    output logic      [MUL_W-1:0]             o_a1,
    output logic      [MUL_W-1:0]             o_b1,
    output logic      [MUL_W-1:0]             o_a2,
    output logic      [MUL_W-1:0]             o_b2,
    input  wire logic [2*MUL_W-1:0]           i_p0,
    input  wire logic [2*MUL_W-1:0]           i_p1,
    input  wire logic [2*MUL_W-1:0]           i_p2,
    output logic      [mbp_pkg::ITER_W-1:0]   o_iter,
    input  wire logic [mbp_pkg::COLOR_W-1:0]  i_color
);

    localparam int F      = FRAC_BITS;
    localparam int MW     = F + 3;
    localparam int XW     = F + 4;
    localparam int SQ_W   = F + 6;
    localparam int NW     = F + 9;
    localparam int HALF_W = mbp_pkg::FRAME_W - 1;
    localparam int OFF_W  = ((DIM_BITS > HALF_W) ? DIM_BITS : HALF_W) + 1;
    localparam int MP_W   = mbp_pkg::PITCH_W + OFF_W - 1;
    localparam int MAP_W  = mbp_pkg::PITCH_W + OFF_W + 1;
    localparam int CX_W   = mbp_pkg::CX_W;
    localparam int IW     = mbp_pkg::ITER_W;

    // +4.0 for the point, 4.0 for the escape test, 8.0 - lsb for the iterate
    localparam logic signed [MAP_W-1:0] MAP_LIM =
        {{(MAP_W-F-3){1'b0}}, 1'b1, {(F+2){1'b0}}};
    localparam logic [SQ_W:0] FOUR = {{(SQ_W-F-2){1'b0}}, 1'b1, {(F+2){1'b0}}};
    localparam logic signed [NW-1:0] X_LIM = {{(NW-F-3){1'b0}}, {(F+3){1'b1}}};

    mbp_pkg::t_state r_state;
    mbp_pkg::t_state n_state;

    logic [OFF_W-2:0]       r_mag_ox;
    logic [OFF_W-2:0]       r_mag_oy;
    logic                   r_neg_ox;
    logic                   r_neg_oy;
    logic signed [XW-1:0]   r_cx;
    logic signed [XW-1:0]   r_cy;
    logic signed [XW-1:0]   r_x;
    logic signed [XW-1:0]   r_y;
    logic [IW-1:0]          r_n;
    logic                   r_out_valid;
    logic [IW-1:0]          r_out_iter;
    logic [mbp_pkg::COLOR_W-1:0] r_out_color;

    logic signed [XW-1:0]   n_cx;
    logic signed [XW-1:0]   n_cy;
    logic signed [XW-1:0]   n_x;
    logic signed [XW-1:0]   n_y;
    logic                   n_out_valid;

    logic                   accept;
    logic                   stop;
    logic                   out_free;
    logic                   load_out;

    // offsets from the frame center
    logic [OFF_W-2:0]       col_ext;
    logic [OFF_W-2:0]       row_ext;
    logic [OFF_W-2:0]       half_w;
    logic [OFF_W-2:0]       half_h;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] noff_x;
    logic signed [OFF_W-1:0] noff_y;

    // mapping
    logic signed [MAP_W-1:0] mp_x;
    logic signed [MAP_W-1:0] mp_y;
    logic signed [MAP_W-1:0] sum_x;
    logic signed [MAP_W-1:0] sum_y;
    logic signed [MAP_W-1:0] clp_x;
    logic signed [MAP_W-1:0] clp_y;

    // iteration
    logic signed [XW-1:0]   neg_x;
    logic signed [XW-1:0]   neg_y;
    logic [MW-1:0]          ax;
    logic [MW-1:0]          ay;
    logic [SQ_W-1:0]        xx;
    logic [SQ_W-1:0]        yy;
    logic [SQ_W:0]          txy;
    logic [SQ_W:0]          sum_sq;
    logic signed [NW-1:0]   txy_s;
    logic signed [NW-1:0]   nx_raw;
    logic signed [NW-1:0]   ny_raw;
    logic signed [NW-1:0]   nx_clp;
    logic signed [NW-1:0]   ny_clp;

    assign accept   = pix.valid && pix.ready;
    assign pix.ready = (r_state == mbp_pkg::ST_IDLE);
    assign out_free = !r_out_valid || res.ready;

    assign res.valid       = r_out_valid;
    assign res.iterations  = r_out_iter;
    assign res.pixel_color = r_out_color;
    assign o_iter          = r_n;

    assign col_ext = (OFF_W-1)'(pix.column);
    assign row_ext = (OFF_W-1)'(pix.row);
    assign half_w  = (OFF_W-1)'(i_cfg.frame_width[mbp_pkg::FRAME_W-1:1]);
    assign half_h  = (OFF_W-1)'(i_cfg.frame_height[mbp_pkg::FRAME_W-1:1]);
    assign off_x   = $signed({1'b0, col_ext}) - $signed({1'b0, half_w});
    assign off_y   = $signed({1'b0, row_ext}) - $signed({1'b0, half_h});
    assign noff_x  = -off_x;
    assign noff_y  = -off_y;

    // point = pitch * offset + center, product magnitude comes from the multipliers
    assign mp_x  = $signed({2'b00, i_p0[MP_W-1:0]});
    assign mp_y  = $signed({2'b00, i_p1[MP_W-1:0]});
    assign sum_x = (r_neg_ox ? -mp_x : mp_x)
                 + {{(MAP_W-CX_W){i_cfg.center_x[CX_W-1]}}, i_cfg.center_x};
    assign sum_y = (r_neg_oy ? -mp_y : mp_y)
                 + {{(MAP_W-CX_W){i_cfg.center_y[CX_W-1]}}, i_cfg.center_y};
    assign clp_x = (sum_x > MAP_LIM) ? MAP_LIM : ((sum_x < -MAP_LIM) ? -MAP_LIM : sum_x);
    assign clp_y = (sum_y > MAP_LIM) ? MAP_LIM : ((sum_y < -MAP_LIM) ? -MAP_LIM : sum_y);
    assign n_cx  = clp_x[XW-1:0];
    assign n_cy  = clp_y[XW-1:0];

    assign neg_x = -r_x;
    assign neg_y = -r_y;
    assign ax    = r_x[XW-1] ? neg_x[MW-1:0] : r_x[MW-1:0];
    assign ay    = r_y[XW-1] ? neg_y[MW-1:0] : r_y[MW-1:0];

    assign xx     = i_p0[2*MW-1:F];
    assign yy     = i_p1[2*MW-1:F];
    assign txy    = i_p2[2*MW-1:F-1];
    assign sum_sq = {1'b0, xx} + {1'b0, yy};
    assign stop   = (r_n == IW'(MAX_ITER)) || (sum_sq >= FOUR);

    assign txy_s  = $signed({2'b00, txy});
    assign nx_raw = $signed({3'b000, xx}) - $signed({3'b000, yy})
                  + {{(NW-XW){r_cx[XW-1]}}, r_cx};
    // sign of 2xy applied after the truncating shift
    assign ny_raw = ((r_x[XW-1] != r_y[XW-1]) ? -txy_s : txy_s)
                  + {{(NW-XW){r_cy[XW-1]}}, r_cy};
    assign nx_clp = (nx_raw > X_LIM) ? X_LIM : ((nx_raw < -X_LIM) ? -X_LIM : nx_raw);
    assign ny_clp = (ny_raw > X_LIM) ? X_LIM : ((ny_raw < -X_LIM) ? -X_LIM : ny_raw);
    assign n_x    = nx_clp[XW-1:0];
    assign n_y    = ny_clp[XW-1:0];

    // multiplier operands: pitch and offset while mapping, |x| and |y| otherwise; the third always takes |x| and |y|
    always_comb begin
        if (r_state == mbp_pkg::ST_MAP_MUL) begin
            o_a0 = MUL_W'(i_cfg.pitch_x);
            o_b0 = MUL_W'(r_mag_ox);
            o_a1 = MUL_W'(i_cfg.pitch_y);
            o_b1 = MUL_W'(r_mag_oy);
        end else begin
            o_a0 = MUL_W'(ax);
            o_b0 = MUL_W'(ax);
            o_a1 = MUL_W'(ay);
            o_b1 = MUL_W'(ay);
        end
        o_a2 = MUL_W'(ax);
        o_b2 = MUL_W'(ay);
    end

    always_comb begin
        n_state  = r_state;
        o_mul_en = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            mbp_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = mbp_pkg::ST_MAP_MUL;
                end
            end
            mbp_pkg::ST_MAP_MUL: begin
                o_mul_en = 1'b1;
                n_state  = mbp_pkg::ST_MAP_ADD;
            end
            mbp_pkg::ST_MAP_ADD: begin
                n_state = mbp_pkg::ST_IT_MUL;
            end
            mbp_pkg::ST_IT_MUL: begin
                o_mul_en = 1'b1;
                n_state  = mbp_pkg::ST_IT_ADD;
            end
            mbp_pkg::ST_IT_ADD: begin
                if (stop) begin
                    n_state = mbp_pkg::ST_DONE;
                end else begin
                    n_state = mbp_pkg::ST_IT_MUL;
                end
            end
            mbp_pkg::ST_DONE: begin
                // wait for the result register to be free
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = mbp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg_ox <= off_x[OFF_W-1];
            r_neg_oy <= off_y[OFF_W-1];
            r_mag_ox <= off_x[OFF_W-1] ? noff_x[OFF_W-2:0] : off_x[OFF_W-2:0];
            r_mag_oy <= off_y[OFF_W-1] ? noff_y[OFF_W-2:0] : off_y[OFF_W-2:0];
        end
        if (r_state == mbp_pkg::ST_MAP_ADD) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_x  <= '0;
            r_y  <= '0;
            r_n  <= '0;
        end
        if ((r_state == mbp_pkg::ST_IT_ADD) && !stop) begin
            r_x <= n_x;
            r_y <= n_y;
            r_n <= r_n + IW'(1);
        end
        if (load_out) begin
            r_out_iter  <= r_n;
            r_out_color <= i_color;
        end
    end

endmodule

`default_nettype wire

>>> src/mandelbrot_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_generator_unit: escape-time mandelbrot pixel generator
// Maps a pixel to a point of the complex plane and returns its escape count
// and color.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix  carries a pixel request (column, row); o_res returns one result
//   (iterations, pixel_color) per request; i_cfg writes the view registers
//   (center, pitch, frame size) and is always ready. Write them while idle.
//   A request is taken only while no pixel is in work. After accept, a
//   multiply state and an add state map the pixel, then each iteration
//   takes a multiply state on the shared multiplier set and an add,
//   compare and clamp state; the last escape test adds one more pair and
//   a done state loads the result register. With one pixel in work at a
//   time, the next request is taken only once the result is loaded.
//   The result sits in an output register: the next request is taken while
//   it waits, and a finished pixel waits in the sequencer until the receiver
//   takes the previous one.
//   Reset loads the default view registers and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_pixel_generator_unit #(
    parameter int MAX_ITER  = mbp_pkg::MAX_ITER_DEF,
    parameter int FRAC_BITS = mbp_pkg::FRAC_BITS_DEF,
    parameter int DIM_BITS  = mbp_pkg::DIM_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mbp_pix_if.sink   i_pix,
    mbp_res_if.source o_res,
    mbp_cfg_if.sink   i_cfg
);

    localparam int MW    = FRAC_BITS + 3;
    localparam int MUL_W = (MW > mbp_pkg::PITCH_W) ? MW : mbp_pkg::PITCH_W;

    mbp_pkg::t_cfg cfg;

    logic                          mul_en;
    logic [MUL_W-1:0]              a0;
    logic [MUL_W-1:0]              b0;
    logic [MUL_W-1:0]              a1;
    logic [MUL_W-1:0]              b1;
    logic [MUL_W-1:0]              a2;
    logic [MUL_W-1:0]              b2;
    logic [2*MUL_W-1:0]            p0;
    logic [2*MUL_W-1:0]            p1;
    logic [2*MUL_W-1:0]            p2;
    logic [mbp_pkg::ITER_W-1:0]    iter;
    logic [mbp_pkg::COLOR_W-1:0]   color;

    mbp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mbp_mul_unit #(
        .MUL_W (MUL_W)
    ) u_mul_unit (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a0  (a0),
        .i_b0  (b0),
        .i_a1  (a1),
        .i_b1  (b1),
        .i_a2  (a2),
        .i_b2  (b2),
        .o_p0  (p0),
        .o_p1  (p1),
        .o_p2  (p2)
    );

    mbp_color #(
        .MAX_ITER (MAX_ITER)
    ) u_color (
        .i_iter  (iter),
        .o_color (color)
    );

    mbp_core #(
        .MAX_ITER  (MAX_ITER),
        .FRAC_BITS (FRAC_BITS),
        .DIM_BITS  (DIM_BITS),
        .MUL_W     (MUL_W)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .pix      (i_pix),
        .res      (o_res),
        .i_cfg    (cfg),
        .o_mul_en (mul_en),
        .o_a0     (a0),
        .o_b0     (b0),
        .o_a1     (a1),
        .o_b1     (b1),
        .o_a2     (a2),
        .o_b2     (b2),
        .i_p0     (p0),
        .i_p1     (p1),
        .i_p2     (p2),
        .o_iter   (iter),
        .i_color  (color)
    );

endmodule

`default_nettype wire

>>> src/mbp_checker.sv
// ----------------------------------------------------------------------------
// mbp_checker: port-level checks of the mandelbrot pixel generator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_checker #(
    parameter int MAX_ITER = mbp_pkg::MAX_ITER_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_pix_valid,
    input wire logic                          i_pix_ready,
    input wire logic                          i_res_valid,
    input wire logic                          i_res_ready,
    input wire logic [mbp_pkg::ITER_W-1:0]    i_res_iter,
    input wire logic [mbp_pkg::COLOR_W-1:0]   i_res_color
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_iter)
            && $stable(i_res_color))
        else $error("result changed while stalled");

    // one pixel in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready |=> !i_pix_ready)
        else $error("request taken while a pixel is in work");

    // points that never escape are black
    a_black_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_iter == mbp_pkg::ITER_W'(MAX_ITER)) |-> (i_res_color == '0))
        else $error("non-escaping point is not black");

    // red and green follow the count
    a_red_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_iter != mbp_pkg::ITER_W'(MAX_ITER))
            |-> (i_res_color[23:16] == i_res_iter)
                && (i_res_color[15:8] == {i_res_iter[3:0], i_res_iter[7:4]}))
        else $error("red or green does not match the count");

endmodule

bind mandelbrot_pixel_generator_unit mbp_checker #(
    .MAX_ITER (MAX_ITER)
) u_mbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_iter  (o_res.iterations),
    .i_res_color (o_res.pixel_color)
);

`default_nettype wire

>>> bench/mbp_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbp_pixel_checker: result checker of the mandelbrot pixel generator
// Tracks the view registers from the write channel, works out escape count
// and color of every accepted pixel request, and compares the returned
// results in order against them.
// ----------------------------------------------------------------------------
module mbp_pixel_checker #(
    parameter int MAX_ITER  = mbp_pkg::MAX_ITER_DEF,
    parameter int FRAC_BITS = mbp_pkg::FRAC_BITS_DEF,
    parameter int DIM_BITS  = mbp_pkg::DIM_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mbp_pix_if        pix,
    mbp_res_if        res,
    mbp_cfg_if        cfg,
    output int        o_fail_cnt,
    output int        o_open_cnt
);
    import mbp_pkg::*;

    typedef struct {
        logic [DIM_BITS-1:0] column;
        logic [DIM_BITS-1:0] row;
        logic [ITER_W-1:0]   iterations;
        logic [COLOR_W-1:0]  pixel_color;
    } t_pixel_shade;

    localparam longint      PLANE_LIMIT = longint'(4) <<< FRAC_BITS;
    localparam longint      ORBIT_LIMIT = (longint'(8) <<< FRAC_BITS) - 1;
    localparam logic [63:0] ESCAPE_SQ   = 64'd4 << FRAC_BITS;

    t_cfg         view;
    t_pixel_shade pending_pixels[$];

    initial begin
        o_fail_cnt = 0;
        o_open_cnt = 0;
    end

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // point = step * (index - size/2) + origin, saturated to +-4
    function automatic longint plane_coord(input logic [DIM_BITS-1:0] idx,
                                           input logic [FRAME_W-1:0] size,
                                           input logic [PITCH_W-1:0] step,
                                           input logic signed [CX_W-1:0] origin);
        longint off;
        off = longint'(idx) - longint'(size >> 1);
        return clip(longint'(step) * off + longint'(origin), PLANE_LIMIT);
    endfunction

    function automatic int orbit_length(input longint c_re, input longint c_im);
        longint      z_re;
        longint      z_im;
        longint      twice;
        logic [63:0] m_re;
        logic [63:0] m_im;
        logic [63:0] sq_re;
        logic [63:0] sq_im;
        int          n;
        z_re = 0;
        z_im = 0;
        for (n = 0; n < MAX_ITER; n++) begin
            m_re  = (z_re < 0) ? 64'(-z_re) : 64'(z_re);
            m_im  = (z_im < 0) ? 64'(-z_im) : 64'(z_im);
            sq_re = (m_re * m_re) >> FRAC_BITS;
            sq_im = (m_im * m_im) >> FRAC_BITS;
            if (sq_re + sq_im >= ESCAPE_SQ) break;
            // cross term on magnitudes, truncated toward zero, sign after
            twice = longint'((m_re * m_im) >> (FRAC_BITS - 1));
            if ((z_re < 0) != (z_im < 0)) twice = -twice;
            z_re = clip(longint'(sq_re) - longint'(sq_im) + c_re, ORBIT_LIMIT);
            z_im = clip(twice + c_im, ORBIT_LIMIT);
        end
        return n;
    endfunction

    function automatic logic [COLOR_W-1:0] shade_of(input int n);
        logic [7:0] cnt;
        logic [7:0] blue;
        if (n == MAX_ITER) return '0;
        cnt  = 8'(n);
        // argument stays within [0, 1], so the sine is never negative
        blue = 8'(127 + int'($floor(127.0 * $sin(real'(n) / 255.0))));
        return {cnt, cnt[3:0], cnt[7:4], blue};
    endfunction

    task automatic flag_failure(input string what, input t_pixel_shade want);
        o_fail_cnt++;
        if (o_fail_cnt <= 10) begin
            $display("%0t: %s: pixel (%0d,%0d) expected iter %0d color %06h, got iter %0d color %06h",
                     $time, what, want.column, want.row, want.iterations, want.pixel_color,
                     res.iterations, res.pixel_color);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_shade want;
        int           n;
        if (!i_rst_n) begin
            view = '{center_x: RST_CENTER_X, center_y: RST_CENTER_Y,
                     pitch_x: RST_PITCH_X, pitch_y: RST_PITCH_Y,
                     frame_width: RST_FRAME_W, frame_height: RST_FRAME_H};
            pending_pixels.delete();
        end else begin
            if (res.valid && res.ready) begin
                if (pending_pixels.size() == 0) begin
                    want = '{default: '0};
                    flag_failure("result with no request pending", want);
                end else begin
                    want = pending_pixels.pop_front();
                    if (res.iterations !== want.iterations) flag_failure("iterations", want);
                    if (res.pixel_color !== want.pixel_color) flag_failure("pixel_color", want);
                end
            end
            if (pix.valid && pix.ready) begin
                want.column = pix.column;
                want.row    = pix.row;
                n = orbit_length(
                    plane_coord(pix.column, view.frame_width, view.pitch_x, view.center_x),
                    plane_coord(pix.row, view.frame_height, view.pitch_y, view.center_y));
                want.iterations  = 8'(n);
                want.pixel_color = shade_of(n);
                pending_pixels.push_back(want);
            end
            // register write lands after the request sampled on the same edge
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_CENTER_X:     view.center_x     = cfg.data[CX_W-1:0];
                    CFG_CENTER_Y:     view.center_y     = cfg.data[CX_W-1:0];
                    CFG_PITCH_X:      view.pitch_x      = cfg.data[PITCH_W-1:0];
                    CFG_PITCH_Y:      view.pitch_y      = cfg.data[PITCH_W-1:0];
                    CFG_FRAME_WIDTH:  view.frame_width  = cfg.data[FRAME_W-1:0];
                    CFG_FRAME_HEIGHT: view.frame_height = cfg.data[FRAME_W-1:0];
                    default: ;
                endcase
            end
        end
        o_open_cnt = pending_pixels.size();
    end

endmodule

>>> bench/tb_mandelbrot_pixel_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_pixel_generator_unit: testbench of the pixel generator
// Loads a series of views (reset view, saturating extremes, zero pitch and
// frame, boundary zooms, raw random words), sends pixel requests in bursts
// against a stalling receiver and lets the checker compare every result.
// ----------------------------------------------------------------------------
module tb_mandelbrot_pixel_generator_unit;
    import mbp_pkg::*;

    localparam int RANDOM_ITEMS = 1230;
    localparam int LONG_HOLD    = 2000;

    typedef enum int {FLOW_OPEN, FLOW_COIN, FLOW_SPARSE, FLOW_MASK} t_flow;
    typedef enum int {VIEW_ZOOM, VIEW_OVERVIEW, VIEW_RAW, VIEW_EXTREME} t_view_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_cnt;
    int   open_cnt;
    int   holds_asked = 0;
    int   holds_done = 0;
    int   burst_left = 0;

    mbp_pix_if #(.DIM_BITS(DIM_BITS_DEF)) pix_bus ();
    mbp_res_if res_bus ();
    mbp_cfg_if cfg_bus ();

    mandelbrot_pixel_generator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    mbp_pixel_checker i_pixel_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .pix        (pix_bus),
        .res        (res_bus),
        .cfg        (cfg_bus),
        .o_fail_cnt (fail_cnt),
        .o_open_cnt (open_cnt)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #25_000_000;
        $display("tb_mandelbrot_pixel_generator_unit failed");
        $finish;
    end

    // receiver: changing stall patterns, plus long hold-offs on request
    initial begin
        t_flow      flow;
        int         span;
        int         step;
        logic [7:0] mask;
        res_bus.ready = 1'b0;
        flow = FLOW_OPEN;
        span = 0;
        step = 0;
        mask = 8'hFF;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                holds_done++;
            end
            if (span == 0) begin
                flow = t_flow'($urandom_range(0, 3));
                span = $urandom_range(8, 300);
                mask = 8'($urandom());
            end
            span--;
            step++;
            case (flow)
                FLOW_OPEN:   res_bus.ready <= 1'b1;
                FLOW_COIN:   res_bus.ready <= 1'($urandom_range(0, 1));
                FLOW_SPARSE: res_bus.ready <= ($urandom_range(0, 3) == 0);
                default:     res_bus.ready <= mask[step % 8];
            endcase
        end
    end

    // all tasks start and end at a falling edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        if (open_cnt != 0) begin
            pix_bus.valid <= 1'b0;
            while (open_cnt != 0) @(negedge i_clk);
        end
    endtask

    task automatic load_view(input logic [31:0] cx, cy, px, py, fw, fh, input bit spare);
        drain();
        cfg_write(CFG_CENTER_X, cx);
        cfg_write(CFG_CENTER_Y, cy);
        cfg_write(CFG_PITCH_X, px);
        cfg_write(CFG_PITCH_Y, py);
        cfg_write(CFG_FRAME_WIDTH, fw);
        cfg_write(CFG_FRAME_HEIGHT, fh);
        // unmapped index, must leave the view alone
        if (spare || $urandom_range(0, 3) == 0) begin
            cfg_write(CFG_IDX_W'(CFG_FRAME_HEIGHT + 1 + $urandom_range(0, 1)), $urandom());
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [DIM_BITS_DEF-1:0] col, row);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 7) begin
                gap = $urandom_range(0, 8);
            end else if ($urandom_range(0, 2) < 2) begin
                gap = $urandom_range(9, 64);
            end else begin
                gap = $urandom_range(65, 600);
            end
            if (gap > 0) begin
                pix_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pix_bus.valid  <= 1'b1;
        pix_bus.column <= col;
        pix_bus.row    <= row;
        do @(posedge i_clk); while (!pix_bus.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] one_of(input logic [31:0] a, b, c);
        case ($urandom_range(0, 2))
            0:       return a;
            1:       return b;
            default: return c;
        endcase
    endfunction

    function automatic logic [DIM_BITS_DEF-1:0] pick_index(input logic [31:0] size);
        int span;
        span = int'(size & 32'h1FFF);
        if (span == 0 || span > 4096 || $urandom_range(0, 4) == 0) begin
            return DIM_BITS_DEF'($urandom_range(0, 4095));
        end
        return DIM_BITS_DEF'($urandom_range(0, span - 1));
    endfunction

    initial begin
        t_view_kind  kind;
        int          span;
        int          sent;
        int          c_re;
        int          c_im;
        int          wait_cnt;
        logic [31:0] d_cx;
        logic [31:0] d_cy;
        logic [31:0] d_px;
        logic [31:0] d_py;
        logic [31:0] d_fw;
        logic [31:0] d_fh;

        i_rst_n        = 1'b0;
        pix_bus.valid  = 1'b0;
        pix_bus.column = '0;
        pix_bus.row    = '0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = CFG_CENTER_X;
        cfg_bus.data   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // view left by reset: corners, frame center inside the set
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd640, 12'd360);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1000, 12'd200);

        // largest centers and pitches: points saturate at the plane edge
        load_view(32'h3FFF_FFFF, 32'h4000_0000, 32'h0FFF_FFFF, 32'h0FFF_FFFF,
                  32'd8191, 32'd8191, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        load_view(32'h4000_0000, 32'h3FFF_FFFF, 32'h0FFF_FFFF, 32'h0FFF_FFFF,
                  32'd4096, 32'd4096, 1'b0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd2048, 12'd2048);

        // zero pitch and frame: c = -2 sits exactly on the escape radius
        load_view(32'hE000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_pixel(12'd5, 12'd7);
        load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_pixel(12'd4095, 12'd1);
        // cusp at 0.25 and the periodic point i never escape
        load_view(32'h0400_0000, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 1'b0);
        send_pixel(12'd3, 12'd2);
        load_view(32'd0, 32'h1000_0000, 32'd0, 32'd0, 32'd1, 32'd1, 1'b0);
        send_pixel(12'd0, 12'd0);

        // tiny frame, pixels far outside it
        load_view(32'hF800_0000, 32'd0, 32'h0100_0000, 32'h0100_0000,
                  32'd16, 32'd16, 1'b1);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd15, 12'd0);
        send_pixel(12'd8, 12'd8);
        // smallest nonzero pitch near the main cardioid edge
        load_view(32'hF400_0000, 32'h0199_999A, 32'd1, 32'd1, 32'd4096, 32'd4096, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = VIEW_ZOOM;
                4, 5, 6:    kind = VIEW_OVERVIEW;
                7, 8:       kind = VIEW_RAW;
                default:    kind = VIEW_EXTREME;
            endcase
            case (kind)
                VIEW_ZOOM: begin
                    d_fw = $urandom_range(1, 256);
                    d_fh = $urandom_range(1, 256);
                    d_px = $urandom_range(1, 1 << 16);
                    d_py = ($urandom_range(0, 1) == 0) ? d_px : $urandom_range(1, 1 << 16);
                    c_re = int'($urandom_range(0, 5 << 27)) - (1 << 29);
                    c_im = int'($urandom_range(0, 5 << 26)) - (5 << 25);
                    d_cx = c_re;
                    d_cy = c_im;
                end
                VIEW_OVERVIEW: begin
                    d_fw = $urandom_range(16, 4096);
                    d_fh = $urandom_range(16, 4096);
                    d_px = (32'd3 << FRAC_BITS_DEF) / d_fw;
                    d_py = (32'd2 << FRAC_BITS_DEF) / d_fh;
                    c_re = -134217728 + int'($urandom_range(0, 1 << 27)) - (1 << 26);
                    c_im = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                    d_cx = c_re;
                    d_cy = c_im;
                end
                VIEW_RAW: begin
                    d_cx = $urandom();
                    d_cy = $urandom();
                    d_px = $urandom();
                    d_py = $urandom();
                    d_fw = $urandom();
                    d_fh = $urandom();
                end
                default: begin
                    d_cx = one_of(32'h4000_0000, 32'h3FFF_FFFF, 32'd0);
                    d_cy = one_of(32'h4000_0000, 32'h3FFF_FFFF, 32'd0);
                    d_px = one_of(32'd0, 32'd1, 32'h0FFF_FFFF);
                    d_py = one_of(32'd0, 32'd1, 32'h0FFF_FFFF);
                    d_fw = one_of(32'd0, 32'd1, ($urandom_range(0, 1) == 0) ? 32'd4096 : 32'd8191);
                    d_fh = one_of(32'd0, 32'd1, ($urandom_range(0, 1) == 0) ? 32'd4096 : 32'd8191);
                end
            endcase
            load_view(d_cx, d_cy, d_px, d_py, d_fw, d_fh, 1'b0);
            span = $urandom_range(20, 120);
            for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
                // receiver holds off while requests keep coming
                if (sent == 300 || sent == 900) holds_asked++;
                if ($urandom_range(0, 63) == 0) drain();
                send_pixel(pick_index(d_fw), pick_index(d_fh));
                sent++;
            end
        end

        pix_bus.valid <= 1'b0;
        wait_cnt = 0;
        while (open_cnt != 0 && wait_cnt < 20000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (600) @(negedge i_clk);
        if (fail_cnt == 0 && open_cnt == 0) begin
            $display("tb_mandelbrot_pixel_generator_unit passed");
        end else begin
            $display("tb_mandelbrot_pixel_generator_unit failed");
        end
        $finish;
    end

endmodule
